[design/egcd_pkg.sv]
// ----------------------------------------------------------------------------
// egcd_pkg
// Shared widths and sequencer state codes for the extended GCD unit.
// ----------------------------------------------------------------------------
package egcd_pkg;

	localparam int WIDTH = 32;
	localparam int CW    = WIDTH + 1;
	localparam int CNT_W = $clog2(WIDTH);

	typedef logic [WIDTH-1:0] opnd_t;
	typedef logic [CW-1:0]    coeff_t;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_CHK  = 5'b00010,
		ST_DIV  = 5'b00100,
		ST_UPD  = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

endpackage

[design/extended_gcd_unit.sv]
// Each Euclid step is a check state (ST_CHK), a radix-2 restoring division of
// WIDTH quotient bits on the shared subtractor (ST_DIV) and an update state
// (ST_UPD). The input stalls while busy, but a new transaction is taken while
// a finished result waits on the output.
// Reset: arst_n asynchronously clears the sequencer and output valid.
// ----------------------------------------------------------------------------
// extended_gcd_unit
// Extended Euclid: gcd and Bezout coefficients by iterated restoring division,
// with quotient-times-coefficient products built bit by bit (Horner form).
// ----------------------------------------------------------------------------
module extended_gcd_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [egcd_pkg::WIDTH-1:0]          a_value,
	input  logic [egcd_pkg::WIDTH-1:0]          b_value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [egcd_pkg::WIDTH-1:0]          divisor,
	output logic signed [egcd_pkg::CW-1:0]      coeff_a,
	output logic signed [egcd_pkg::CW-1:0]      coeff_b
);
	import egcd_pkg::*;

	state_t           state_q;
	opnd_t            rprev_q, rcur_q, dvd_q, rem_q;
	coeff_t           xprev_q, xcur_q, yprev_q, ycur_q, px_q, py_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	opnd_t            div_q;
	coeff_t           ca_q, cb_q;

	logic [WIDTH:0]   rem_sh, diff;
	logic             qbit;
	opnd_t            rem_n;
	coeff_t           px_n, py_n;

	always_comb begin
		rem_sh = {rem_q, dvd_q[WIDTH-1]};
		diff   = rem_sh - {1'b0, rcur_q};
		qbit   = ~diff[WIDTH];
		rem_n  = qbit ? diff[WIDTH-1:0] : rem_sh[WIDTH-1:0];
		px_n   = {px_q[CW-2:0], 1'b0} + (qbit ? xcur_q : '0);
		py_n   = {py_q[CW-2:0], 1'b0} + (qbit ? ycur_q : '0);
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign divisor   = div_q;
	assign coeff_a   = ca_q;
	assign coeff_b   = cb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && (!out_valid_q || !out_stall))
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid)
						state_q <= ST_CHK;
				end
				ST_CHK: begin
					state_q <= (rcur_q == '0) ? ST_DONE : ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == CNT_W'(WIDTH-1))
						state_q <= ST_UPD;
				end
				ST_UPD: begin
					state_q <= ST_CHK;
				end
				ST_DONE: begin
					if (!out_valid_q || !out_stall)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				rprev_q <= a_value;
				rcur_q  <= b_value;
				xprev_q <= CW'(1);
				xcur_q  <= '0;
				yprev_q <= '0;
				ycur_q  <= CW'(1);
			end
			ST_CHK: begin
				dvd_q <= rprev_q;
				rem_q <= '0;
				px_q  <= '0;
				py_q  <= '0;
				cnt_q <= '0;
			end
			ST_DIV: begin
				dvd_q <= {dvd_q[WIDTH-2:0], 1'b0};
				rem_q <= rem_n;
				px_q  <= px_n;
				py_q  <= py_n;
				cnt_q <= cnt_q + CNT_W'(1);
			end
			ST_UPD: begin
				rprev_q <= rcur_q;
				rcur_q  <= rem_q;
				xprev_q <= xcur_q;
				xcur_q  <= xprev_q - px_q;
				yprev_q <= ycur_q;
				ycur_q  <= yprev_q - py_q;
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					div_q <= rprev_q;
					ca_q  <= xprev_q;
					cb_q  <= yprev_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

[design/egcd_checker.sv]
// ----------------------------------------------------------------------------
// egcd_checker
// Port-level checks for the extended GCD unit, bound into every extended_gcd_unit.
// ----------------------------------------------------------------------------
module egcd_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_stall,
	input logic [egcd_pkg::WIDTH-1:0]     a_value,
	input logic [egcd_pkg::WIDTH-1:0]     b_value,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [egcd_pkg::WIDTH-1:0]     divisor,
	input logic signed [egcd_pkg::CW-1:0] coeff_a,
	input logic signed [egcd_pkg::CW-1:0] coeff_b
);
	import egcd_pkg::*;

	// busy after every accepted transaction
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input not stalled after transaction");

	// a new result follows a busy cycle
	a_res_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without work");

	// a zero gcd comes with coefficients 1 and 0, as for two zero operands
	a_zero_gcd: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && divisor == '0) |-> (coeff_a == CW'(1) && coeff_b == '0))
		else $error("bad coefficients for zero gcd");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(divisor)
			&& $stable(coeff_a) && $stable(coeff_b)))
		else $error("stalled result changed");

	// stalled operands are held
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_stall) |=> (in_valid && $stable(a_value)
			&& $stable(b_value)))
		else $error("stalled operands changed");

endmodule

bind extended_gcd_unit egcd_checker u_egcd_checker (.*);

[tb/sv/extended_gcd_unit_tb.sv]
// ----------------------------------------------------------------------------
// extended_gcd_unit_tb
// Self-checking bench for the extended GCD unit. Operand pairs go in through
// the valid/stall input port. Each pair is run through a local extended Euclid
// predictor. The gcd and both Bezout coefficients of every output transaction
// are checked in order. The pairs cover zero operands, all-ones operands,
// Fibonacci worst-case chains and random mixes. Both ports idle at random.
// ----------------------------------------------------------------------------
module extended_gcd_unit_tb;

	import egcd_pkg::*;

	typedef struct packed {
		opnd_t  divisor;
		coeff_t coeff_a;
		coeff_t coeff_b;
	} bezout_t;

	localparam int MAX_GAP     = 19;
	localparam int RANDOM_RUNS = 370;
	localparam int SETTLE_CYC  = 1700;

	logic   clk = 1'b0;
	logic   arst_n;
	logic   in_valid;
	logic   in_stall;
	opnd_t  a_value;
	opnd_t  b_value;
	logic   out_valid;
	logic   out_stall;
	opnd_t  divisor;
	coeff_t coeff_a;
	coeff_t coeff_b;

	bezout_t pending_results[$];
	int      mismatch_count = 0;
	int      pairs_sent     = 0;
	int      results_seen   = 0;
	bit      no_idle        = 1'b0;

	extended_gcd_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.a_value   (a_value),
		.b_value   (b_value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.divisor   (divisor),
		.coeff_a   (coeff_a),
		.coeff_b   (coeff_b)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic bezout_t predict_bezout(opnd_t a, opnd_t b);
		logic [63:0] r_prev, r_cur, r_next;
		logic [63:0] x_prev, x_cur, x_next;
		logic [63:0] y_prev, y_cur, y_next;
		logic [63:0] q;
		bezout_t     res;
		r_prev = 64'(a);
		r_cur  = 64'(b);
		x_prev = 64'd1;
		x_cur  = 64'd0;
		y_prev = 64'd0;
		y_cur  = 64'd1;
		while (r_cur != 64'd0) begin
			q      = r_prev / r_cur;
			r_next = r_prev - q * r_cur;
			x_next = x_prev - q * x_cur;
			y_next = y_prev - q * y_cur;
			r_prev = r_cur;
			r_cur  = r_next;
			x_prev = x_cur;
			x_cur  = x_next;
			y_prev = y_cur;
			y_cur  = y_next;
		end
		res.divisor = r_prev[WIDTH-1:0];
		res.coeff_a = x_prev[CW-1:0];
		res.coeff_b = y_prev[CW-1:0];
		return res;
	endfunction

	function automatic opnd_t fibonacci(int n);
		logic [63:0] f0, f1, t;
		f0 = 64'd0;
		f1 = 64'd1;
		for (int i = 0; i < n; i++) begin
			t  = f0 + f1;
			f0 = f1;
			f1 = t;
		end
		return f0[WIDTH-1:0];
	endfunction

	function automatic int draw_gap();
		if (no_idle)
			return 0;
		return $urandom_range(0, MAX_GAP);
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] MISMATCH: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// One input transaction; valid is left high after acceptance and only
	// lowered on the next falling edge if a gap is drawn.
	task automatic send_operands(input opnd_t a, input opnd_t b);
		int gap;
		gap = draw_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		a_value  <= a;
		b_value  <= b;
		in_valid <= 1'b1;
		forever begin
			@(posedge clk);
			if (!in_stall)
				break;
		end
		pending_results.push_back(predict_bezout(a, b));
		pairs_sent++;
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Output side: random stall before each transaction, then check it.
	initial begin
		int      gap;
		bezout_t want;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			gap = draw_gap();
			@(negedge clk);
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(negedge clk);
			end
			out_stall <= 1'b0;
			do
				@(posedge clk);
			while (out_valid !== 1'b1);
			results_seen++;
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result gcd=%0d", divisor));
			end else begin
				want = pending_results.pop_front();
				if (divisor !== want.divisor)
					report_mismatch($sformatf("divisor %0d, want %0d",
						divisor, want.divisor));
				if (coeff_a !== want.coeff_a)
					report_mismatch($sformatf("coeff_a %0d, want %0d",
						$signed(coeff_a), $signed(want.coeff_a)));
				if (coeff_b !== want.coeff_b)
					report_mismatch($sformatf("coeff_b %0d, want %0d",
						$signed(coeff_b), $signed(want.coeff_b)));
			end
		end
	end

	task automatic test_zero_operands();
		send_operands('0, '0);
		send_operands(32'd5, '0);
		send_operands('0, 32'd7);
		send_operands('1, '0);
		send_operands('0, '1);
		send_operands(32'd1, 32'd1);
	endtask

	task automatic test_extreme_operands();
		send_operands('1, '1);
		send_operands('1, 32'd1);
		send_operands(32'd1, '1);
		send_operands('1, '1 - 32'd1);
		send_operands(32'h8000_0000, 32'h7fff_ffff);
		send_operands(32'h8000_0000, 32'h0001_0000);
		send_operands(32'haaaa_aaaa, 32'h5555_5555);
		send_operands(32'd12, 32'd18);
		send_operands(32'd240, 32'd46);
	endtask

	// consecutive Fibonacci numbers give the longest remainder chains
	task automatic test_worst_case_steps();
		send_operands(fibonacci(47), fibonacci(46));
		send_operands(fibonacci(46), fibonacci(47));
		send_operands(fibonacci(45), fibonacci(44));
	endtask

	task automatic test_random_operands();
		opnd_t a, b, g;
		int    n;
		for (int i = 0; i < RANDOM_RUNS; i++) begin
			no_idle = (i >= 120 && i < 170);
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					a = $urandom();
					b = $urandom();
				end
				4: begin
					a = $urandom_range(0, 255);
					b = $urandom_range(0, 255);
				end
				5: begin
					a = $urandom();
					b = '0;
					if ($urandom_range(0, 1))
						{a, b} = {b, a};
				end
				6: begin
					b = $urandom_range(1, 65535);
					a = b * $urandom_range(0, 65535);
				end
				7: begin
					g = $urandom_range(1, 1023);
					a = g * $urandom_range(0, 65535);
					b = g * $urandom_range(0, 65535);
				end
				8: begin
					a = $urandom();
					b = a + $urandom_range(0, 2) - 1;
				end
				default: begin
					n = $urandom_range(30, 47);
					a = fibonacci(n);
					b = fibonacci(n - 1);
				end
			endcase
			send_operands(a, b);
			if (i == 200)
				drain_results();
		end
		no_idle = 1'b0;
	endtask

	initial begin
		arst_n   = 1'b0;
		in_valid = 1'b0;
		a_value  = '0;
		b_value  = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_zero_operands();
		test_extreme_operands();
		drain_results();
		test_worst_case_steps();
		test_random_operands();
		drain_results();
		repeat (SETTLE_CYC) @(posedge clk);

		$display("Run covered %0d operand pairs: zero, extreme, worst-case and random.",
			pairs_sent);
		$display("%0d results compared, %0d mismatches.", results_seen, mismatch_count);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("extended_gcd_unit verification clean");
		else
			$display("extended_gcd_unit verification failed");
		$finish;
	end

	initial begin
		#6000000;
		$display("Timed out with %0d results outstanding.", pending_results.size());
		$display("extended_gcd_unit verification failed");
		$finish;
	end

endmodule
